// ===== hdl/sba_pkg.sv =====
`timescale 1ns / 1ps

package sba_pkg;

   typedef enum logic [1:0] {
      KIND_ALLOC = 2'd0,
      KIND_FREE  = 2'd1,
      KIND_CHECK = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_SUBST     = 3'd1,
      ST_FULL      = 3'd2,
      ST_EXHAUSTED = 3'd3,
      ST_FREE_EMPTY = 3'd4,
      ST_MISMATCH  = 3'd5,
      ST_OUTSTANDING = 3'd6
   } status_type;

   localparam int unsigned KIND_W   = 2;
   localparam int unsigned SIZE_W   = 16;
   localparam int unsigned ADDR_W   = 32;
   localparam int unsigned LEN_W    = 12;
   localparam int unsigned STATUS_W = 3;

   localparam logic [SIZE_W-1:0] SUBST_BYTES = 16'd28;
   localparam logic [SIZE_W-1:0] ALIGN_MASK  = 16'hfffc;
   localparam logic [SIZE_W-1:0] ALIGN_ADD   = 16'd3;

   typedef struct packed {
      logic capture;
      logic commit;
   } dp_cmd_type;

endpackage

// ===== hdl/sba_ctrl.sv =====
`timescale 1ns / 1ps

module sba_ctrl
   import sba_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   output dp_cmd_type dp_cmd,
   output logic       rsp_valid
);

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      valid_ff;
   logic      valid_in;

   always_comb begin
      state_in       = state_ff;
      valid_in       = 1'b0;
      dp_cmd.capture = 1'b0;
      dp_cmd.commit  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               dp_cmd.capture = 1'b1;
               state_in       = S_EXEC;
            end
         end
         S_EXEC: begin
            dp_cmd.commit = 1'b1;
            valid_in      = 1'b1;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = valid_ff;

   a_accept_exec : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not enter execute");

   a_exec_once : assert property (@(posedge clock) disable iff (reset)
      busy |=> (!busy && rsp_valid))
      else $error("execute did not end in one cycle with a result");

   a_rsp_origin : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result beat without execute");

endmodule

// ===== hdl/sba_dp.sv =====
`timescale 1ns / 1ps

module sba_dp
   import sba_pkg::*;
#(
   parameter int unsigned MAX_BLOCKS = 16,
   parameter int unsigned POOL_BYTES = 2048
)
(
   input  logic                clock,
   input  logic                reset,
   input  dp_cmd_type          dp_cmd,
   input  logic                csr_wr_en,
   input  logic [ADDR_W-1:0]   csr_wr_data,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [SIZE_W-1:0]   req_size,
   input  logic [ADDR_W-1:0]   req_free_addr,
   output logic [ADDR_W-1:0]   rsp_block_addr,
   output logic [LEN_W-1:0]    rsp_granted_size,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_is_empty
);

   localparam int unsigned IDX_W   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int unsigned DEPTH_W = $clog2(MAX_BLOCKS + 1);
   localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_BLOCKS);
   localparam logic [SIZE_W:0]    POOL_LIM  = (SIZE_W + 1)'(POOL_BYTES);

   logic [LEN_W-1:0] len_mem [MAX_BLOCKS];

   logic [ADDR_W-1:0]   base_ff;
   logic [DEPTH_W-1:0]  depth_ff, depth_in;
   logic [SIZE_W-1:0]   used_ff, used_in;
   logic [LEN_W-1:0]    top_len_ff;
   kind_type            kind_ff;
   logic [SIZE_W-1:0]   size_ff;
   logic [ADDR_W-1:0]   faddr_ff;

   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [LEN_W-1:0]    granted_ff, granted_in;
   status_type          status_ff, status_in;
   logic                empty_ff, empty_in;

   logic                push;
   logic [IDX_W-1:0]    rd_idx;
   logic [IDX_W-1:0]    wr_idx;
   logic [DEPTH_W-1:0]  depth_dec;

   logic                subst;
   logic [SIZE_W-1:0]   size_eff;
   logic [SIZE_W-1:0]   len_raw;
   logic [SIZE_W-1:0]   len_rnd;
   logic [SIZE_W:0]     used_sum;
   logic [SIZE_W-1:0]   used_pop;
   logic [ADDR_W-1:0]   addr_push;
   logic [ADDR_W-1:0]   addr_pop;

   function automatic logic req_size_chk(input logic [SIZE_W-1:0] sz);
      req_size_chk = (sz == '0) || ({1'b0, sz} > POOL_LIM);
   endfunction

   assign depth_dec = depth_ff - DEPTH_W'(1);
   assign rd_idx    = depth_dec[IDX_W-1:0];
   assign wr_idx    = depth_ff[IDX_W-1:0];

   assign subst     = (req_size_chk(size_ff));
   assign size_eff  = subst ? '0 : size_ff;
   assign len_raw   = subst ? SUBST_BYTES : size_ff;
   assign len_rnd   = (len_raw + ALIGN_ADD) & ALIGN_MASK;
   assign used_sum  = {1'b0, used_ff} + {1'b0, len_rnd};
   assign used_pop  = used_ff - {{(SIZE_W-LEN_W){1'b0}}, top_len_ff};
   assign addr_push = base_ff + {{(ADDR_W-SIZE_W){1'b0}}, used_ff};
   assign addr_pop  = base_ff + {{(ADDR_W-SIZE_W){1'b0}}, used_pop};

   always_comb begin
      push       = 1'b0;
      depth_in   = depth_ff;
      used_in    = used_ff;
      addr_in    = '0;
      granted_in = '0;
      status_in  = ST_OK;
      empty_in   = 1'b0;
      case (kind_ff)
         KIND_ALLOC: begin
            addr_in    = addr_push;
            granted_in = size_eff[LEN_W-1:0];
            if (depth_ff == DEPTH_MAX) begin
               status_in = ST_FULL;
            end else begin
               push     = 1'b1;
               depth_in = depth_ff + DEPTH_W'(1);
               used_in  = used_sum[SIZE_W-1:0];
               if (used_sum > POOL_LIM) begin
                  status_in = ST_EXHAUSTED;
               end else if (subst) begin
                  status_in = ST_SUBST;
               end
            end
         end
         KIND_FREE: begin
            if (depth_ff == '0) begin
               status_in = ST_FREE_EMPTY;
            end else begin
               addr_in  = addr_pop;
               depth_in = depth_dec;
               used_in  = used_pop;
               if (faddr_ff != addr_pop) begin
                  status_in = ST_MISMATCH;
               end
            end
         end
         KIND_CHECK: begin
            if (depth_ff == '0) begin
               empty_in = 1'b1;
            end else begin
               status_in = ST_OUTSTANDING;
               depth_in  = '0;
               used_in   = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      top_len_ff <= len_mem[rd_idx];
      if (dp_cmd.commit && push) begin
         len_mem[wr_idx] <= len_rnd[LEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         kind_ff  <= kind_type'(req_kind);
         size_ff  <= req_size;
         faddr_ff <= req_free_addr;
      end
      if (dp_cmd.commit) begin
         addr_ff    <= addr_in;
         granted_ff <= granted_in;
         status_ff  <= status_in;
         empty_ff   <= empty_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         depth_ff <= '0;
         used_ff  <= '0;
      end else begin
         if (csr_wr_en) begin
            base_ff <= csr_wr_data;
         end
         if (dp_cmd.commit) begin
            depth_ff <= depth_in;
            used_ff  <= used_in;
         end
      end
   end

   assign rsp_block_addr   = addr_ff;
   assign rsp_granted_size = granted_ff;
   assign rsp_status       = status_ff;
   assign rsp_is_empty     = empty_ff;

   a_depth_range : assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DEPTH_MAX)
      else $error("stack depth beyond table size");

   a_depth_quiet : assert property (@(posedge clock) disable iff (reset)
      !$past(dp_cmd.commit) |-> $stable(depth_ff) && $stable(used_ff))
      else $error("stack state moved without commit");

   a_empty_zero : assert property (@(posedge clock) disable iff (reset)
      (depth_ff == '0) |-> (used_ff == '0))
      else $error("bytes in use with empty stack");

endmodule

// ===== hdl/stack_buffer_allocator_unit.sv =====
`timescale 1ns / 1ps
// Channel   Ports                                             Handshake
// request   req_kind, req_size, req_free_addr                 start && !busy
// result    rsp_block_addr, rsp_granted_size, rsp_status,     rsp_valid, one cycle
//           rsp_is_empty
// config    csr_wr_data (pool_base)                           csr_wr_en
//
// Each beat is accepted, then executed against the length stack, whose top
// entry is read from a registered memory port in the accept cycle.
// The result shows in the cycle after execute; a new beat may be accepted then.
// Synchronous reset clears depth, bytes in use and pool_base; stack memory
// contents are not cleared. The receiver cannot stall results.

module stack_buffer_allocator_unit
   import sba_pkg::*;
#(
   parameter int unsigned MAX_BLOCKS = 16,
   parameter int unsigned POOL_BYTES = 2048
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [SIZE_W-1:0]   req_size,
   input  logic [ADDR_W-1:0]   req_free_addr,
   output logic                rsp_valid,
   output logic [ADDR_W-1:0]   rsp_block_addr,
   output logic [LEN_W-1:0]    rsp_granted_size,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_is_empty,
   input  logic                csr_wr_en,
   input  logic [ADDR_W-1:0]   csr_wr_data
);

   dp_cmd_type dp_cmd;

   sba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .dp_cmd    (dp_cmd),
      .rsp_valid (rsp_valid)
   );

   sba_dp #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .POOL_BYTES (POOL_BYTES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .dp_cmd           (dp_cmd),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_kind         (req_kind),
      .req_size         (req_size),
      .req_free_addr    (req_free_addr),
      .rsp_block_addr   (rsp_block_addr),
      .rsp_granted_size (rsp_granted_size),
      .rsp_status       (rsp_status),
      .rsp_is_empty     (rsp_is_empty)
   );

endmodule
